// ===== rtl/strang_splitting_oscillator_step_top_assert.svh =====
// Assertion macros for the oscillator step block.
// Used by the top level only; holds nothing but macro definitions.
`ifndef STRANG_SPLITTING_OSCILLATOR_STEP_TOP_ASSERT_SVH
`define STRANG_SPLITTING_OSCILLATOR_STEP_TOP_ASSERT_SVH

// Implication in the same cycle.
`define SSOS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define SSOS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssos_pkg.sv =====
// Shared types, constants and helpers for the oscillator step block.
// No dependencies; used by every module of the block.
package ssos_pkg;

   localparam int VALUE_W    = 32;
   localparam int FRAC_W     = 24;
   localparam int DECAY_W    = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CNT_W      = 6;
   localparam logic [DECAY_W-1:0] ONE_Q = DECAY_W'(1) << FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRIFT_ROW_FIRST  = 3'd0,
      CSR_DRIFT_ROW_SECOND = 3'd1,
      CSR_NOISE_ROW_FIRST  = 3'd2,
      CSR_NOISE_ROW_SECOND = 3'd3,
      CSR_DECAY_FACTOR     = 3'd4,
      CSR_HALF_STEP_DRIFT  = 3'd5
   } csr_index_type;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic signed [VALUE_W-1:0]  value_first;
      logic signed [VALUE_W-1:0]  value_second;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  state_first;
      logic signed [VALUE_W-1:0]  state_second;
      logic                       saturated;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0]                drift_row_first;
      logic [63:0]                drift_row_second;
      logic [63:0]                noise_row_first;
      logic [63:0]                noise_row_second;
      logic [DECAY_W-1:0]         decay_factor;
      logic signed [VALUE_W-1:0]  half_step_drift;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_T, ST_LD, ST_SQRT, ST_DIVLD, ST_DIV, ST_FIN,
      ST_LIN, ST_LINEND, ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MUL_SQ, MUL_T, MUL_LIN
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic [2:0]  lin_idx;
      logic        acc_clr;
      logic        acc_en;
      logic        acc_row;
      logic        sqrt_ld;
      logic        sqrt_step;
      logic        div_ld;
      logic        div_step;
      logic        fin;
      logic        lin_end;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic root_zero;
   } status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               clip;
   } sat_type;

   // Clips a wide signed value to the state range and reports the clip.
   function automatic sat_type sat_val(input logic signed [47:0] v);
      sat_type r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r.value = 32'h7FFF_FFFF;
         r.clip  = 1'b1;
      end else if (v < -48'sh0000_8000_0000) begin
         r.value = 32'h8000_0000;
         r.clip  = 1'b1;
      end else begin
         r.value = v[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   // Magnitude of a signed state word as an unsigned word.
   function automatic logic [VALUE_W-1:0] mag32(input logic [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? (~v + VALUE_W'(1)) : v;
   endfunction

endpackage

// ===== rtl/ssos_ctrl.sv =====
// Sequencer for the oscillator step block.
// Depends on ssos_pkg; drives commands into ssos_dp.
module ssos_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   input  logic                  rsp_free,
   input  ssos_pkg::status_type  status,
   output logic                  req_stall,
   output ssos_pkg::cmd_type     cmd
);
   import ssos_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             phase_ff, phase_in;
   logic [3:0]       lin_prev;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   assign lin_prev = cnt_ff[3:0] - 4'd1;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.mul_sel = MUL_SQ;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               phase_in = 1'b0;
               state_in = (req_kind == REQ_STEP) ? ST_SQ : ST_OUT;
            end
         end
         ST_SQ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SQ;
            state_in    = ST_T;
         end
         ST_T: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T;
            state_in    = ST_LD;
         end
         ST_LD: begin
            cmd.sqrt_ld = 1'b1;
            cnt_in      = CNT_W'(31);
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DIVLD;
            end
         end
         ST_DIVLD: begin
            cmd.div_ld = 1'b1;
            cnt_in     = CNT_W'(55);
            state_in   = status.root_zero ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            cnt_in   = '0;
            state_in = phase_ff ? ST_OUT : ST_LIN;
         end
         ST_LIN: begin
            // Products issue at counts 0..7 and each is summed at the next count.
            cmd.mul_sel = MUL_LIN;
            cmd.mul_en  = (cnt_ff < CNT_W'(8));
            cmd.lin_idx = cnt_ff[2:0];
            cmd.acc_clr = (cnt_ff == '0);
            cmd.acc_en  = (cnt_ff != '0);
            cmd.acc_row = lin_prev[2];
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(8)) begin
               state_in = ST_LINEND;
            end
         end
         ST_LINEND: begin
            cmd.lin_end = 1'b1;
            phase_in    = 1'b1;
            state_in    = ST_SQ;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ssos_dp.sv =====
// Datapath of the oscillator step block: state, shared multiplier,
// square root and divider. Depends on ssos_pkg; driven by ssos_ctrl.
module ssos_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ssos_pkg::cmd_type     cmd,
   input  ssos_pkg::req_item_type req_item,
   input  ssos_pkg::cfg_type     cfg,
   output ssos_pkg::status_type  status,
   output ssos_pkg::rsp_item_type result
);
   import ssos_pkg::*;

   logic [VALUE_W-1:0] w0_ff, w0_in, w1_ff, w1_in;
   logic [VALUE_W-1:0] n0_ff, n1_ff;
   logic               clip_ff, clip_in;
   logic [39:0]        prod_ff;
   logic               prod_neg_ff;
   logic signed [41:0] acc0_ff, acc1_ff;
   logic [63:0]        rad_ff;
   logic [33:0]        rem_ff;
   logic [31:0]        root_ff;
   logic [55:0]        num_ff, quo_ff;
   logic [32:0]        drem_ff;

   logic [VALUE_W-1:0] ax, coef, opnd;
   logic [DECAY_W-1:0] e_q, ome;
   logic [38:0]        mul_a;
   logic [31:0]        mul_b;
   logic               mul_neg;
   logic [70:0]        mprod, mrnd;
   logic signed [41:0] pterm;
   logic [39:0]        d_sum;
   logic [33:0]        rcat, trial;
   logic [32:0]        dcat;
   logic               qclip;
   logic [30:0]        qv;
   sat_type            drift_sat, acc0_sat, acc1_sat;

   assign ax  = mag32(w0_ff);
   assign e_q = (cfg.decay_factor > ONE_Q) ? ONE_Q : cfg.decay_factor;
   assign ome = ONE_Q - e_q;

   always_comb begin
      case (cmd.lin_idx)
         3'd0: coef = cfg.drift_row_first[63:32];
         3'd1: coef = cfg.drift_row_first[31:0];
         3'd2: coef = cfg.noise_row_first[63:32];
         3'd3: coef = cfg.noise_row_first[31:0];
         3'd4: coef = cfg.drift_row_second[63:32];
         3'd5: coef = cfg.drift_row_second[31:0];
         3'd6: coef = cfg.noise_row_second[63:32];
         default: coef = cfg.noise_row_second[31:0];
      endcase
      case (cmd.lin_idx[1:0])
         2'd0: opnd = w0_ff;
         2'd1: opnd = w1_ff;
         2'd2: opnd = n0_ff;
         default: opnd = n1_ff;
      endcase
      case (cmd.mul_sel)
         MUL_SQ: begin
            mul_a   = {7'b0, ax};
            mul_b   = ax;
            mul_neg = 1'b0;
         end
         MUL_T: begin
            mul_a   = prod_ff[38:0];
            mul_b   = {7'b0, ome};
            mul_neg = 1'b0;
         end
         default: begin
            mul_a   = {7'b0, mag32(coef)};
            mul_b   = mag32(opnd);
            mul_neg = coef[31] ^ opnd[31];
         end
      endcase
   end

   // Rounded magnitude product, ties away from zero.
   assign mprod = {32'b0, mul_a} * {39'b0, mul_b};
   assign mrnd  = mprod + (71'(1) << (FRAC_W - 1));

   assign pterm = prod_neg_ff ? -$signed({2'b0, prod_ff}) : $signed({2'b0, prod_ff});
   assign d_sum = 40'(e_q) + prod_ff;

   assign rcat  = {rem_ff[31:0], rad_ff[63:62]};
   assign trial = {root_ff, 2'b01};
   assign dcat  = {drem_ff[31:0], num_ff[55]};

   assign qclip = |quo_ff[55:31];
   assign qv    = qclip ? 31'h7FFF_FFFF : quo_ff[30:0];

   assign drift_sat = sat_val(48'(signed'(w1_ff)) + 48'(cfg.half_step_drift));
   assign acc0_sat  = sat_val(48'(acc0_ff));
   assign acc1_sat  = sat_val(48'(acc1_ff));

   always_comb begin
      w0_in   = w0_ff;
      w1_in   = w1_ff;
      clip_in = clip_ff;
      if (cmd.load) begin
         clip_in = 1'b0;
         if (req_item.req_type == REQ_START) begin
            w0_in = req_item.value_first;
            w1_in = req_item.value_second;
         end
      end else if (cmd.fin) begin
         w0_in   = w0_ff[31] ? -{1'b0, qv} : {1'b0, qv};
         w1_in   = drift_sat.value;
         clip_in = clip_ff | qclip | drift_sat.clip;
      end else if (cmd.lin_end) begin
         w0_in   = acc0_sat.value;
         w1_in   = acc1_sat.value;
         clip_in = clip_ff | acc0_sat.clip | acc1_sat.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff   <= '0;
         w1_ff   <= '0;
         clip_ff <= 1'b0;
      end else begin
         w0_ff   <= w0_in;
         w1_ff   <= w1_in;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_item.req_type == REQ_STEP) begin
         n0_ff <= req_item.value_first;
         n1_ff <= req_item.value_second;
      end
      if (cmd.mul_en) begin
         prod_ff     <= mrnd[63:24];
         prod_neg_ff <= mul_neg;
      end
      if (cmd.acc_clr) begin
         acc0_ff <= '0;
         acc1_ff <= '0;
      end else if (cmd.acc_en) begin
         if (cmd.acc_row) begin
            acc1_ff <= acc1_ff + pterm;
         end else begin
            acc0_ff <= acc0_ff + pterm;
         end
      end
      if (cmd.sqrt_ld) begin
         rad_ff  <= {d_sum, 24'b0};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rcat >= trial) begin
            rem_ff  <= rcat - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rcat;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
      if (cmd.div_ld) begin
         num_ff  <= {ax, 24'b0};
         drem_ff <= '0;
         quo_ff  <= (status.root_zero && ax != '0) ? 56'(ONE_Q) : '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[54:0], 1'b0};
         if (dcat >= {1'b0, root_ff}) begin
            drem_ff <= dcat - {1'b0, root_ff};
            quo_ff  <= {quo_ff[54:0], 1'b1};
         end else begin
            drem_ff <= dcat;
            quo_ff  <= {quo_ff[54:0], 1'b0};
         end
      end
   end

   assign status.root_zero    = (root_ff == '0);
   assign result.state_first  = w0_ff;
   assign result.state_second = w1_ff;
   assign result.saturated    = clip_ff;

endmodule

// ===== rtl/strang_splitting_oscillator_step_top.sv =====
// Top level of the Strang-splitting oscillator step block.
// Depends on ssos_pkg, ssos_ctrl, ssos_dp and the assertion macro header.
//
// Usage: an item on the req_ channel is either a start item, which loads the
// two-component Q8.24 state and echoes it, or a step item, which carries two
// noise samples and advances the state by one splitting step. Every item gives
// exactly one item on the rsp_ channel with the new state and a flag that is
// set when any value was clipped. Coefficients are written through the csr_
// port while the block is idle.
// A start item goes from the idle state through the output state into the
// output register. Each of a step item's two nonlinear half steps runs a one
// bit per cycle square root (32-bit root) and divider (56-bit quotient), and
// the linear map runs eight products through one shared multiplier. A half step
// whose root is zero skips the divider. One item is worked on at a time;
// req_stall is low only while the sequencer waits for an item.
// The result sits in an output register, so a stalled receiver holds only the
// finished item; the block finishes a later item and then waits for the slot.
// Synchronous reset clears the state to zero, restores the register defaults
// (decay factor one, all else zero) and empties the output register.
module strang_splitting_oscillator_step_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ssos_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ssos_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_wr_en,
   input  logic [ssos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssos_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ssos_pkg::*;

`include "strang_splitting_oscillator_step_top_assert.svh"

   cfg_type      cfg_ff, cfg_in;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   cmd_type      cmd;
   status_type   status;
   rsp_item_type result;
   logic         rsp_free;

   // Register writes; unused indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DRIFT_ROW_FIRST:  cfg_in.drift_row_first  = csr_wdata;
            CSR_DRIFT_ROW_SECOND: cfg_in.drift_row_second = csr_wdata;
            CSR_NOISE_ROW_FIRST:  cfg_in.noise_row_first  = csr_wdata;
            CSR_NOISE_ROW_SECOND: cfg_in.noise_row_second = csr_wdata;
            CSR_DECAY_FACTOR:     cfg_in.decay_factor     = csr_wdata[DECAY_W-1:0];
            CSR_HALF_STEP_DRIFT:  cfg_in.half_step_drift  = csr_wdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{decay_factor: ONE_Q, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output slot: free when empty or when its item leaves this cycle.
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= result;
      end
   end

   ssos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.req_type),
      .rsp_free  (rsp_free),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   ssos_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .status   (status),
      .result   (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // An accepted item keeps the block busy in the next cycle.
   `SSOS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block took a second item while busy")
   // A loaded result shows up as valid in the next cycle.
   `SSOS_ASSERT_NEXT(a_load_gives_valid, clock, reset, cmd.rsp_load, rsp_valid, "loaded result not presented")
   // A result is only loaded into a free slot.
   `SSOS_ASSERT_SAME(a_load_into_free, clock, reset, cmd.rsp_load, !rsp_valid || !rsp_stall, "result overwrote a held item")

endmodule
